// File: src/lkv_pkg.sv
`timescale 1ns / 1ps

package lkv_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [KEY_W-1:0] key_t;
    typedef logic [VAL_W-1:0] val_t;
    typedef logic [CAP_W-1:0] cap_t;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam val_t MISS_VALUE = '1;
    localparam val_t PUT_VALUE = '0;
    localparam cap_t CAP_RESET = 5'd16;

endpackage

// File: src/lkv_ram.sv
`timescale 1ns / 1ps

module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/lru_key_value_cache.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-------------------------------------
// in       | input     | in_valid / in_stall  | operation, item_key, item_value
// out      | output    | out_valid / out_stall| hit, read_value
// cfg      | input     | cfg_valid / cfg_ready| capacity_in_use
//
// A transaction is taken in S_IDLE, scanned in S_SCAN, settled in S_DECIDE and its
// result is loaded in S_RESULT; the scan ends when the key is found or every occupied
// entry is compared. The next transaction is taken once the cache is back in S_IDLE.
// The key and value memories are scanned one entry per cycle through their single
// read port, so the scan visits the occupied entries in index order.
// Reset empties the cache at once: no clearing pass, entries are only read
// below the fill count. A stalled result holds in the output register while
// the next transaction is taken and scanned.

module lru_key_value_cache (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              operation,
    input  logic signed [lkv_pkg::KEY_W-1:0]  item_key,
    input  logic signed [lkv_pkg::VAL_W-1:0]  item_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic signed [lkv_pkg::VAL_W-1:0]  read_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0]         capacity_in_use
);

    import lkv_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_RESULT
    } state_t;

    state_t state_reg;
    logic   op_reg;
    key_t   key_reg;
    val_t   val_reg;
    val_t   hit_val_reg;
    cnt_t   scan_idx_reg;
    idx_t   cmp_idx_reg;
    logic   cmp_valid_reg;
    logic   found_reg;
    idx_t   slot_reg;
    idx_t   lru_reg;
    cnt_t   count_reg;
    cap_t   cap_reg;
    idx_t   rank_reg [MAX_ENTRIES];
    logic   out_valid_reg;
    logic   hit_reg;
    val_t   read_value_reg;

    key_t        key_rdata;
    val_t        val_rdata;
    logic        issue_en;
    logic        key_match;
    logic        scan_done;
    logic [31:0] cap_ext;
    logic [31:0] eff_cap;
    logic        full;
    idx_t        victim;
    cnt_t        promote_rank;
    cnt_t        last_rank;
    logic        ram_we;
    cnt_t        scan_idx_next;

    assign issue_en      = (state_reg == S_SCAN) && (scan_idx_reg < count_reg);
    assign key_match     = cmp_valid_reg && (key_rdata == key_reg);
    assign scan_done     = !issue_en && !cmp_valid_reg;
    assign scan_idx_next = scan_idx_reg + CNT_W'(1);
    assign last_rank     = count_reg - CNT_W'(1);

    assign cap_ext = 32'(cap_reg);
    assign eff_cap = (cap_ext == 32'd0) ? 32'd1 :
                     ((cap_ext > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES) : cap_ext);
    assign full    = 32'(count_reg) >= eff_cap;

    always_comb
    begin
        if (found_reg)
        begin
            victim       = slot_reg;
            promote_rank = CNT_W'(rank_reg[slot_reg]);
        end
        else if (full)
        begin
            victim       = lru_reg;
            promote_rank = last_rank;
        end
        else
        begin
            victim       = count_reg[IDX_W-1:0];
            promote_rank = count_reg;
        end
    end

    assign ram_we = (state_reg == S_DECIDE) && (op_reg == OP_PUT);

    lkv_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (victim),
        .wdata (key_reg),
        .re    (issue_en),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (key_rdata)
    );

    lkv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ENTRIES)
    ) u_val_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (victim),
        .wdata (val_reg),
        .re    (issue_en),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (val_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_GET;
            key_reg        <= '0;
            val_reg        <= '0;
            hit_val_reg    <= '0;
            scan_idx_reg   <= '0;
            cmp_idx_reg    <= '0;
            cmp_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            slot_reg       <= '0;
            lru_reg        <= '0;
            count_reg      <= '0;
            cap_reg        <= CAP_RESET;
            out_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            read_value_reg <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                cap_reg <= capacity_in_use;
            end

            if (out_valid_reg && !out_stall && (state_reg != S_RESULT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg        <= operation;
                        key_reg       <= item_key;
                        val_reg       <= item_value;
                        scan_idx_reg  <= '0;
                        cmp_valid_reg <= 1'b0;
                        found_reg     <= 1'b0;
                        lru_reg       <= '0;
                        state_reg     <= S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    cmp_valid_reg <= issue_en;
                    cmp_idx_reg   <= scan_idx_reg[IDX_W-1:0];
                    if (issue_en)
                    begin
                        scan_idx_reg <= scan_idx_next;
                    end
                    // track the least recent slot for a possible eviction
                    if (cmp_valid_reg && (CNT_W'(rank_reg[cmp_idx_reg]) == last_rank))
                    begin
                        lru_reg <= cmp_idx_reg;
                    end
                    if (key_match)
                    begin
                        found_reg   <= 1'b1;
                        slot_reg    <= cmp_idx_reg;
                        hit_val_reg <= val_rdata;
                        state_reg   <= S_DECIDE;
                    end
                    else if (scan_done)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end

                S_DECIDE:
                begin
                    if (found_reg || (op_reg == OP_PUT))
                    begin
                        for (int i = 0; i < MAX_ENTRIES; i++)
                        begin
                            if ((CNT_W'(i) < count_reg) &&
                                (CNT_W'(rank_reg[i]) < promote_rank))
                            begin
                                rank_reg[i] <= rank_reg[i] + IDX_W'(1);
                            end
                        end
                        rank_reg[victim] <= '0;
                    end
                    if ((op_reg == OP_PUT) && !found_reg && !full)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    state_reg <= S_RESULT;
                end

                S_RESULT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        hit_reg       <= found_reg;
                        if (op_reg == OP_PUT)
                        begin
                            read_value_reg <= PUT_VALUE;
                        end
                        else if (found_reg)
                        begin
                            read_value_reg <= hit_val_reg;
                        end
                        else
                        begin
                            read_value_reg <= MISS_VALUE;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;
    assign cfg_ready  = 1'b1;

endmodule

// File: src/lkv_checker.sv
`timescale 1ns / 1ps

module lkv_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              operation,
    input  logic signed [lkv_pkg::KEY_W-1:0]  item_key,
    input  logic signed [lkv_pkg::VAL_W-1:0]  item_value,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic                              hit,
    input  logic signed [lkv_pkg::VAL_W-1:0]  read_value,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0]         capacity_in_use
);

    import lkv_pkg::*;

    logic unused_ok;

    assign unused_ok = operation ^ (^item_key) ^ (^item_value) ^ cfg_valid ^ cfg_ready ^
                       (^capacity_in_use);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(read_value))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again straight after a transaction");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a transaction in progress");

    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> (read_value == MISS_VALUE) || (read_value == PUT_VALUE))
        else $error("miss carried a stored value");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);
